// ===== hdl/bbg_pkg.sv =====
package bbg_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int IMG_W_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // input beat commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;

  // floor(x/9) = (x * 7282) >> 16 for every 3x3 sum of 8-bit pixels
  localparam int                 SUM_W       = 12;
  localparam int                 RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP9      = 13'd7282;
  localparam int                 RECIP_SHIFT = 16;
  localparam int                 PROD_W      = SUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic drain;     // drain beat, no line store write
    logic emit;      // produces an output pixel
    logic interior;  // output is the 3x3 mean, else a copy
    logic last;      // final output pixel of the image
    logic sel_a;     // drain reads the newer line store
  } item_meta_t;

  localparam int META_W = $bits(item_meta_t);

endpackage

// ===== hdl/box_blur_3x3_gray_unit.sv =====
// 3x3 box filter for an 8-bit grayscale raster stream.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// image width, index 1 the height. Every write restarts the image. cfg_ready
// is always high; write only while the block is idle.
// Input channel (in_valid/in_ready): cmd 0 carries one pixel, cmd 1 is a
// drain beat. Pixel beats after the image is complete and drain beats before
// it is complete are consumed without a result.
// Output channel (out_valid/out_ready): one pixel per result beat in raster
// order; frame_last marks the final pixel of the image. Interior pixels are
// the truncated mean of their 3x3 neighbourhood, border pixels are copied.
// Output pixel q is caused by input pixel q+width+1, or by a drain beat for
// the last width+1 pixels, and is registered in the queue, s1, s2, s3 and the output.
// Throughput is one beat per cycle while the output is not stalled: the line
// stores are single-port-write, single-port-read RAMs touched once per beat,
// and the 3x3 sum and the reciprocal multiply each take a stage of their own.
// A 4-entry queue lets input beats keep landing while out_ready is low; in_ready
// falls once it fills. Reset restores width 640, height 480 and empties the
// pipe; line store contents are undefined until written.
module box_blur_3x3_gray_unit #(
  parameter  int MAX_WIDTH = 1024,
  localparam int AW        = $clog2(MAX_WIDTH),
  localparam int QW        = AW + bbg_pkg::PIX_W + bbg_pkg::META_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [bbg_pkg::PIX_W-1:0]      pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bbg_pkg::PIX_W-1:0]      pixel_out,
  output logic                           frame_last
);

  logic                         push, pop, avail;
  bbg_pkg::item_meta_t          push_meta, head_meta;
  logic [bbg_pkg::PIX_W-1:0]    push_pix, head_pix;
  logic [AW-1:0]                push_addr, head_addr;
  logic [QW-1:0]                head;

  assign cfg_ready = 1'b1;

  bbg_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .pixel_in  (pixel_in),
    .push      (push),
    .push_meta (push_meta),
    .push_pix  (push_pix),
    .push_addr (push_addr)
  );

  bbg_queue #(.WIDTH(QW), .DEPTH(bbg_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_addr, push_pix, push_meta}),
    .space     (in_ready),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  assign {head_addr, head_pix, head_meta} = head;

  bbg_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .avail      (avail),
    .head_meta  (head_meta),
    .head_pix   (head_pix),
    .head_addr  (head_addr),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

// ===== hdl/bbg_ram.sv =====
module bbg_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/bbg_front.sv =====
module bbg_front #(
  parameter  int MAX_WIDTH = 1024,
  localparam int AW        = $clog2(MAX_WIDTH),
  localparam int WW        = $clog2(MAX_WIDTH + 1),
  localparam int RW        = bbg_pkg::ROW_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [bbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           cmd,
  input  logic [bbg_pkg::PIX_W-1:0]      pixel_in,
  output logic                           push,
  output bbg_pkg::item_meta_t            push_meta,
  output logic [bbg_pkg::PIX_W-1:0]      push_pix,
  output logic [AW-1:0]                  push_addr
);

  logic [bbg_pkg::IMG_W_W-1:0] image_width;
  logic [RW-1:0]               image_height;
  logic [WW-1:0]               w_eff, w_last;
  logic [RW-1:0]               h_eff, h_last;

  logic [RW-1:0] in_row, in_row_next, out_row, out_row_next;
  logic [AW-1:0] in_col, in_col_next, out_col, out_col_next;

  logic in_done, in_col_last, out_col_last, p_ready, out_last;
  logic is_pix, is_drain, emit;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff = (image_height == '0) ? RW'(1) : image_height;
  end

  assign w_last = w_eff - WW'(1);
  assign h_last = h_eff - RW'(1);

  assign in_done      = in_row >= h_eff;
  assign in_col_last  = WW'(in_col) == w_last;
  assign out_col_last = WW'(out_col) == w_last;
  assign out_last     = (out_row == h_last) && out_col_last;
  // input index has reached width+1
  assign p_ready      = (in_row >= RW'(2)) || ((in_row == RW'(1)) && (in_col != '0));

  assign is_pix   = in_valid && in_ready && (cmd == bbg_pkg::CMD_PIXEL) && !in_done;
  assign is_drain = in_valid && in_ready && (cmd == bbg_pkg::CMD_DRAIN) && in_done;
  assign emit     = is_drain || (is_pix && p_ready);
  assign push     = is_pix || is_drain;

  always_comb begin
    push_meta.drain    = cmd == bbg_pkg::CMD_DRAIN;
    push_meta.emit     = emit;
    push_meta.interior = (out_row != '0) && (out_row < h_last) &&
                         (out_col != '0) && (WW'(out_col) < w_last);
    push_meta.last     = out_last;
    push_meta.sel_a    = out_row >= h_last;
  end

  assign push_pix  = pixel_in;
  assign push_addr = (cmd == bbg_pkg::CMD_DRAIN) ? out_col : in_col;

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (is_pix) begin
      if (in_col_last) begin
        in_col_next = '0;
        in_row_next = in_row + RW'(1);
      end else begin
        in_col_next = in_col + AW'(1);
      end
    end
    if (emit) begin
      priority if (out_last) begin
        in_row_next  = '0;
        in_col_next  = '0;
        out_row_next = '0;
        out_col_next = '0;
      end else if (out_col_last) begin
        out_col_next = '0;
        out_row_next = out_row + RW'(1);
      end else begin
        out_col_next = out_col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bbg_pkg::WIDTH_RESET;
      image_height <= bbg_pkg::HEIGHT_RESET;
      in_row       <= '0;
      in_col       <= '0;
      out_row      <= '0;
      out_col      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bbg_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[bbg_pkg::IMG_W_W-1:0];
        bbg_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[RW-1:0];
        default: ;
      endcase
      // any register write starts a new image
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
    end
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (WW'(in_col) < w_eff) && (WW'(out_col) < w_eff))
    else $error("column counter beyond image width");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    push && push_meta.emit && push_meta.last |=>
      (in_row == '0) && (out_row == '0) && (out_col == '0))
    else $error("counters not cleared after final output");
`endif

endmodule

// ===== hdl/bbg_queue.sv =====
module bbg_queue #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int PW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  input  logic             pop,
  output logic             avail,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign space = count != CW'(DEPTH);
  assign avail = count != '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue overflow");
`endif

endmodule

// ===== hdl/bbg_back.sv =====
module bbg_back #(
  parameter  int MAX_WIDTH = 1024,
  localparam int AW        = $clog2(MAX_WIDTH),
  localparam int PW        = bbg_pkg::PIX_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  bbg_pkg::item_meta_t head_meta,
  input  logic [PW-1:0]       head_pix,
  input  logic [AW-1:0]       head_addr,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PW-1:0]       pixel_out,
  output logic                frame_last
);

  logic adv;

  logic                s1_valid, s2_valid, s3_valid;
  bbg_pkg::item_meta_t s1_meta, s2_meta, s3_meta;
  logic [PW-1:0]       s1_pix;
  logic [AW-1:0]       s1_addr;
  logic                s1_fwd;
  logic                s1_write;

  logic [PW-1:0] rd_a, rd_b, a_old, b_old, fwd_a, fwd_b;
  logic [PW-1:0] win [9];

  logic [PW-1:0]                 s2_drain_val, s3_drain_val, s3_center;
  logic [bbg_pkg::SUM_W-1:0]     sum, s3_sum;
  logic [PW+1:0]                 row0, row1, row2;
  logic [bbg_pkg::PROD_W-1:0]    prod;
  logic [PW-1:0]                 result;

  // whole pipe moves together; the queue in front takes up the slack
  assign adv      = !out_valid || out_ready;
  assign pop      = adv && avail;
  assign s1_write = adv && s1_valid && !s1_meta.drain;

  bbg_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk     (clk),
    .we      (s1_write),
    .wr_addr (s1_addr),
    .wr_data (s1_pix),
    .re      (adv),
    .rd_addr (head_addr),
    .rd_data (rd_a)
  );

  bbg_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk     (clk),
    .we      (s1_write),
    .wr_addr (s1_addr),
    .wr_data (a_old),
    .re      (adv),
    .rd_addr (head_addr),
    .rd_data (rd_b)
  );

  // read issued in the same edge as a write to the same column sees old data
  assign a_old = s1_fwd ? fwd_a : rd_a;
  assign b_old = s1_fwd ? fwd_b : rd_b;

  always_comb begin
    row0 = (PW+2)'(win[0]) + (PW+2)'(win[1]) + (PW+2)'(win[2]);
    row1 = (PW+2)'(win[3]) + (PW+2)'(win[4]) + (PW+2)'(win[5]);
    row2 = (PW+2)'(win[6]) + (PW+2)'(win[7]) + (PW+2)'(win[8]);
    sum  = bbg_pkg::SUM_W'(row0) + bbg_pkg::SUM_W'(row1) + bbg_pkg::SUM_W'(row2);
  end

  assign prod = bbg_pkg::PROD_W'(s3_sum) * bbg_pkg::PROD_W'(bbg_pkg::RECIP9);

  always_comb begin
    priority if (s3_meta.interior) begin
      result = prod[bbg_pkg::RECIP_SHIFT +: PW];
    end else if (s3_meta.drain) begin
      result = s3_drain_val;
    end else begin
      result = s3_center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (adv) begin
      s1_valid  <= avail;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && s3_meta.emit;
      if (s1_valid && !s1_meta.drain) begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= b_old;
        win[3] <= win[4];
        win[4] <= win[5];
        win[5] <= a_old;
        win[6] <= win[7];
        win[7] <= win[8];
        win[8] <= s1_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_meta <= head_meta;
      s1_pix  <= head_pix;
      s1_addr <= head_addr;
      s1_fwd  <= s1_valid && !s1_meta.drain && (s1_addr == head_addr);
      if (s1_valid && !s1_meta.drain) begin
        fwd_a <= s1_pix;
        fwd_b <= a_old;
      end
      s2_meta      <= s1_meta;
      s2_drain_val <= s1_meta.sel_a ? a_old : b_old;
      s3_meta      <= s2_meta;
      s3_sum       <= sum;
      s3_center    <= win[4];
      s3_drain_val <= s2_drain_val;
      pixel_out    <= result;
      frame_last   <= s3_meta.last;
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(s1_valid) && $stable(s2_valid) && $stable(s3_valid))
    else $error("pipeline moved during output stall");
`endif

endmodule
